// File: design/mhp_pkg.sv
// Shared types, constants and a helper function for the MAC header parser.
package mhp_pkg;

  // Frame length limit and the width of the byte position counter
  localparam int MAX_FRAME_BYTES = 256;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE_MASK    = 3'd0,
    REG_MAKER_MASK_0 = 3'd1,
    REG_MAKER_MASK_1 = 3'd2,
    REG_MAKER_MASK_2 = 3'd3,
    REG_MAKER_MASK_3 = 3'd4
  } cfg_reg_t;

  // Header flag bit positions
  localparam int FLAG_EXT = 3;
  localparam int FLAG_FWD = 2;
  localparam int FLAG_UNI = 1;
  localparam int FLAG_SIG = 0;

  // Fixed header byte positions
  localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SRC_MAKER = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SRC_ID_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SRC_ID_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_EXT       = POS_W'(4);
  localparam logic [POS_W-1:0] POS_MAX       = POS_W'(MAX_FRAME_BYTES);

  // Acceptance masks
  typedef struct packed {
    logic [63:0]      type_mask;
    logic [3:0][63:0] maker_mask;
  } mhp_masks_t;

  // One result item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        frame_end;
    logic [3:0]  header_flags;
    logic [5:0]  frame_type;
    logic [1:0]  ack_mode;
    logic [7:0]  src_maker;
    logic [15:0] src_id;
    logic [7:0]  dst_maker;
    logic [15:0] dst_id;
    logic [31:0] signature_word;
    logic        frame_ok;
  } mhp_result_t;

  // Look up a manufacturer code in its quarter of the maker masks
  function automatic logic maker_ok(input mhp_masks_t m, input logic [7:0] maker);
    return m.maker_mask[maker[7:6]][maker[5:0]];
  endfunction

endpackage

// File: design/mhp_cfg_regs.sv
// Configuration mask registers of the MAC header parser.
module mhp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                  cfg_wdata,
  output mhp_pkg::mhp_masks_t          masks
);

  mhp_pkg::mhp_masks_t masks_r;
  mhp_pkg::mhp_masks_t masks_nxt;

  // Decode the write into the addressed mask; drop writes beyond the list
  always_comb begin
    masks_nxt = masks_r;
    if (cfg_we) begin
      unique case (mhp_pkg::cfg_reg_t'(cfg_index))
        mhp_pkg::REG_TYPE_MASK:    masks_nxt.type_mask     = cfg_wdata;
        mhp_pkg::REG_MAKER_MASK_0: masks_nxt.maker_mask[0] = cfg_wdata;
        mhp_pkg::REG_MAKER_MASK_1: masks_nxt.maker_mask[1] = cfg_wdata;
        mhp_pkg::REG_MAKER_MASK_2: masks_nxt.maker_mask[2] = cfg_wdata;
        mhp_pkg::REG_MAKER_MASK_3: masks_nxt.maker_mask[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the masks; reset accepts everything
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= '1;
    end else begin
      masks_r <= masks_nxt;
    end
  end

  assign masks = masks_r;

endmodule

// File: design/mhp_decode.sv
// Input register, frame state and header decode of the MAC header parser.
module mhp_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_last_byte,
  input  mhp_pkg::mhp_masks_t masks,
  input  logic                out_free,
  output logic                res_load,
  output mhp_pkg::mhp_result_t res
);

  localparam int POS_W = mhp_pkg::POS_W;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  // Frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       flag_r, flag_nxt;
  logic [5:0]       type_r, type_nxt;
  logic [1:0]       ack_r, ack_nxt;
  logic [7:0]       src_maker_r, src_maker_nxt;
  logic [15:0]      src_id_r, src_id_nxt;
  logic [7:0]       dst_maker_r, dst_maker_nxt;
  logic [15:0]      dst_id_r, dst_id_nxt;
  logic [31:0]      sig_r, sig_nxt;
  logic             err_r, err_nxt;

  logic             ext, uni, sig;
  logic [POS_W-1:0] base, sig_start, sig_off, hdr_len;
  logic             payload;
  logic             res_valid;
  logic             s1_go;
  logic             fire;

  assign ext = flag_r[mhp_pkg::FLAG_EXT];
  assign uni = flag_r[mhp_pkg::FLAG_UNI];
  assign sig = flag_r[mhp_pkg::FLAG_SIG];

  // Decode the held byte against its place in the header
  always_comb begin
    flag_nxt      = flag_r;
    type_nxt      = type_r;
    ack_nxt       = ack_r;
    src_maker_nxt = src_maker_r;
    src_id_nxt    = src_id_r;
    dst_maker_nxt = dst_maker_r;
    dst_id_nxt    = dst_id_r;
    sig_nxt       = sig_r;
    err_nxt       = err_r;
    payload       = 1'b0;
    base          = ext ? (mhp_pkg::POS_EXT + POS_W'(1)) : mhp_pkg::POS_EXT;
    sig_start     = base + (uni ? POS_W'(3) : POS_W'(0));
    sig_off       = pos_r - sig_start;

    if (pos_r == mhp_pkg::POS_TYPE) begin
      flag_nxt = {byte_r[7], byte_r[6], 2'b00};
      type_nxt = byte_r[5:0];
      if (!masks.type_mask[byte_r[5:0]]) err_nxt = 1'b1;
    end else if (pos_r == mhp_pkg::POS_SRC_MAKER) begin
      src_maker_nxt = byte_r;
      if (!mhp_pkg::maker_ok(masks, byte_r)) err_nxt = 1'b1;
    end else if (pos_r == mhp_pkg::POS_SRC_ID_LO) begin
      src_id_nxt = {8'h00, byte_r};
    end else if (pos_r == mhp_pkg::POS_SRC_ID_HI) begin
      src_id_nxt = {byte_r, src_id_r[7:0]};
    end else if (pos_r == mhp_pkg::POS_EXT && ext) begin
      // Extended byte: ack mode, unicast and signature flags
      ack_nxt = byte_r[7:6];
      if (byte_r[5]) flag_nxt[mhp_pkg::FLAG_UNI] = 1'b1;
      if (byte_r[4]) flag_nxt[mhp_pkg::FLAG_SIG] = 1'b1;
      if (byte_r[7:6] != 2'b00 && !byte_r[5]) err_nxt = 1'b1;
    end else if (uni && pos_r == base) begin
      dst_maker_nxt = byte_r;
      if (!mhp_pkg::maker_ok(masks, byte_r)) err_nxt = 1'b1;
    end else if (uni && pos_r == base + POS_W'(1)) begin
      dst_id_nxt = {8'h00, byte_r};
    end else if (uni && pos_r == base + POS_W'(2)) begin
      dst_id_nxt = {byte_r, dst_id_r[7:0]};
    end else if (sig && pos_r >= sig_start && pos_r < sig_start + POS_W'(4)) begin
      // Little-endian signature, one byte lane per position
      sig_nxt = sig_r | ({24'h000000, byte_r} << {sig_off[1:0], 3'b000});
    end else if (pos_r < mhp_pkg::POS_MAX) begin
      payload = 1'b1;
    end

    // Count bytes, saturating at the frame limit
    pos_nxt = (pos_r < mhp_pkg::POS_MAX) ? pos_r + POS_W'(1) : pos_r;

    hdr_len = POS_W'(4)
            + (flag_nxt[mhp_pkg::FLAG_EXT] ? POS_W'(1) : POS_W'(0))
            + (flag_nxt[mhp_pkg::FLAG_UNI] ? POS_W'(3) : POS_W'(0))
            + (flag_nxt[mhp_pkg::FLAG_SIG] ? POS_W'(4) : POS_W'(0));
  end

  // Build the result item
  always_comb begin
    res              = '0;
    res.payload_byte = payload ? byte_r : 8'h00;
    res.has_payload  = payload;
    if (last_r) begin
      res.frame_end      = 1'b1;
      res.header_flags   = flag_nxt;
      res.frame_type     = type_nxt;
      res.ack_mode       = ack_nxt;
      res.src_maker      = src_maker_nxt;
      res.src_id         = src_id_nxt;
      res.dst_maker      = dst_maker_nxt;
      res.dst_id         = dst_id_nxt;
      res.signature_word = sig_nxt;
      res.frame_ok       = !err_nxt && (pos_nxt >= hdr_len);
    end
  end

  // Advance the held item unless its result finds the output full
  assign res_valid    = payload || last_r;
  assign s1_go        = !res_valid || out_free;
  assign fire         = s1_valid_r && s1_go;
  assign res_load     = fire && res_valid;
  assign in_ready     = !s1_valid_r || s1_go;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
      last_r <= in_last_byte;
    end
  end

  // Frame state: update per item, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_r)) begin
      pos_r       <= '0;
      flag_r      <= '0;
      type_r      <= '0;
      ack_r       <= '0;
      src_maker_r <= '0;
      src_id_r    <= '0;
      dst_maker_r <= '0;
      dst_id_r    <= '0;
      sig_r       <= '0;
      err_r       <= 1'b0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      flag_r      <= flag_nxt;
      type_r      <= type_nxt;
      ack_r       <= ack_nxt;
      src_maker_r <= src_maker_nxt;
      src_id_r    <= src_id_nxt;
      dst_maker_r <= dst_maker_nxt;
      dst_id_r    <= dst_id_nxt;
      sig_r       <= sig_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// File: design/mhp_out_reg.sv
// Result register of the MAC header parser.
module mhp_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_load,
  input  mhp_pkg::mhp_result_t res,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mhp_pkg::mhp_result_t out_res
);

  logic                 valid_r, valid_nxt;
  mhp_pkg::mhp_result_t res_r;

  // Free when empty or when the held item leaves this cycle
  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new item; hold while stalled
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: design/mac_header_parser.sv
// Top level of the MAC header parser: byte stream in, payload and header report out.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_ready     | in_rx_byte, in_last_byte
//  out     | out_valid / out_ready   | out_payload_byte .. out_frame_ok
//  cfg     | cfg_we                  | cfg_index, cfg_wdata (five 64-bit masks)
//
// One item a cycle while no result stalls: an item is held in the input
// register while its header byte is decoded, and its result is then loaded
// into the result register. Header bytes that are not last give no result
// and leave the input register without waiting on the output. A stalled
// result holds the result register; the input register keeps taking items
// until it too is full. Reset clears the frame state and sets all masks to
// accept everything.
module mac_header_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_has_payload,
  output logic                          out_frame_end,
  output logic [3:0]                    out_header_flags,
  output logic [5:0]                    out_frame_type,
  output logic [1:0]                    out_ack_mode,
  output logic [7:0]                    out_src_maker,
  output logic [15:0]                   out_src_id,
  output logic [7:0]                    out_dst_maker,
  output logic [15:0]                   out_dst_id,
  output logic [31:0]                   out_signature_word,
  output logic                          out_frame_ok,
  input  logic                          cfg_we,
  input  logic [mhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);

  mhp_pkg::mhp_masks_t  masks;
  mhp_pkg::mhp_result_t res;
  mhp_pkg::mhp_result_t out_res;
  logic                 res_load;
  logic                 out_free;

  mhp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .masks     (masks)
  );

  mhp_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .in_last_byte (in_last_byte),
    .masks        (masks),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res)
  );

  mhp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Unpack the result item onto its ports
  assign out_payload_byte   = out_res.payload_byte;
  assign out_has_payload    = out_res.has_payload;
  assign out_frame_end      = out_res.frame_end;
  assign out_header_flags   = out_res.header_flags;
  assign out_frame_type     = out_res.frame_type;
  assign out_ack_mode       = out_res.ack_mode;
  assign out_src_maker      = out_res.src_maker;
  assign out_src_id         = out_res.src_id;
  assign out_dst_maker      = out_res.dst_maker;
  assign out_dst_id         = out_res.dst_id;
  assign out_signature_word = out_res.signature_word;
  assign out_frame_ok       = out_res.frame_ok;

endmodule

// File: design/mhp_checker.sv
// Port-level checks of the MAC header parser and their bind to the top level.
module mhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_payload_byte,
  input logic        out_has_payload,
  input logic        out_frame_end,
  input logic [3:0]  out_header_flags,
  input logic [5:0]  out_frame_type,
  input logic [1:0]  out_ack_mode,
  input logic [15:0] out_src_id,
  input logic [31:0] out_signature_word,
  input logic        out_frame_ok
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_end) && $stable(out_signature_word))
    else $error("result item changed while stalled");

  // Every item either carries payload or ends a frame
  a_item_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_has_payload || out_frame_end)
    else $error("result item with neither payload nor frame end");

  // Header report is zero away from the frame end
  a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_header_flags == 4'h0 && out_frame_type == 6'h00
      && out_src_id == 16'h0000 && out_signature_word == 32'h0 && !out_frame_ok)
    else $error("header fields set on a payload-only item");

  // An accepted frame never asks for ack without unicast
  a_ack_uni: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |-> out_ack_mode == 2'b00 || out_header_flags[1])
    else $error("frame_ok with ack request but no unicast");

  // No payload means the payload byte reads zero
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_payload |-> out_payload_byte == 8'h00)
    else $error("payload byte set without payload");

endmodule

bind mac_header_parser mhp_checker u_mhp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_payload_byte   (out_payload_byte),
  .out_has_payload    (out_has_payload),
  .out_frame_end      (out_frame_end),
  .out_header_flags   (out_header_flags),
  .out_frame_type     (out_frame_type),
  .out_ack_mode       (out_ack_mode),
  .out_src_id         (out_src_id),
  .out_signature_word (out_signature_word),
  .out_frame_ok       (out_frame_ok)
);
